// ===== hw/rtl/sjt_pkg.sv =====
// ----------------------------------------------------------------------------
// sjt_pkg
// Shared types, constants and a helper for the plain-changes swap sequencer.
// ----------------------------------------------------------------------------
package sjt_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int N_W          = 5;
    localparam int POS_W        = 4;
    localparam int FIRST_LEVEL  = 2;
    localparam int LAST_LEVEL   = MAX_ELEMENTS - 1;
    localparam logic [N_W-1:0] N_RESET = 5'd4;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } sjt_result_t;

    // Clamp the element count register into the supported range.
    function automatic logic [N_W-1:0] eff_n(input logic [N_W-1:0] n);
        logic [N_W-1:0] r;
        r = n;
        if (n < N_W'(2))
        begin
            r = N_W'(2);
        end
        else if (n > N_W'(MAX_ELEMENTS))
        begin
            r = N_W'(MAX_ELEMENTS);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sjt_levels.sv =====
// ----------------------------------------------------------------------------
// sjt_levels
// Per-level position counters and sweep directions, with the combinational
// carry across levels that picks the next swap position.
// ----------------------------------------------------------------------------
module sjt_levels
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      advance,
    input  logic                      restart,
    input  logic [sjt_pkg::N_W-1:0]   n_eff,
    output sjt_pkg::sjt_result_t      result
);

    localparam int LO = sjt_pkg::FIRST_LEVEL;
    localparam int HI = sjt_pkg::LAST_LEVEL;
    localparam int PW = sjt_pkg::POS_W;

    // Level m is stored at index m-1, so index li has last position li.
    logic [PW-1:0] step_reg  [LO:HI];
    logic [PW-1:0] step_next [LO:HI];
    logic          dir_reg   [LO:HI];
    logic          dir_next  [LO:HI];
    logic          phase_reg;
    logic          phase_next;

    logic [PW-1:0] cur_step [LO:HI];
    logic          cur_dir  [LO:HI];
    logic          cur_phase;
    logic [HI:LO]  in_range;
    logic [HI:LO]  at_end;
    logic [HI:LO]  above_done;
    logic [HI:LO]  emit_here;
    logic [HI:LO]  wrap_here;
    logic [HI:LO]  carry_up;
    logic          any_emit;
    logic [PW-1:0] val;
    logic [PW-1:0] offset;

    always_comb
    begin
        cur_phase = restart ? 1'b0 : phase_reg;
        for (int li = LO; li <= HI; li++)
        begin
            cur_step[li] = restart ? '0 : step_reg[li];
            cur_dir[li]  = restart ? 1'b1 : dir_reg[li];
            in_range[li] = sjt_pkg::N_W'(li) < n_eff;
            at_end[li]   = cur_step[li] == PW'(li);
        end

        // A level moves only when every in-range level above it sits at the end of a half.
        above_done[HI] = 1'b1;
        for (int li = HI - 1; li >= LO; li--)
        begin
            above_done[li] = above_done[li+1] & (~in_range[li+1] | at_end[li+1]);
        end

        val = '0;
        for (int li = LO; li <= HI; li++)
        begin
            emit_here[li] = in_range[li] & ~at_end[li] & above_done[li];
            wrap_here[li] = in_range[li] & at_end[li] & above_done[li];
            carry_up[li]  = wrap_here[li] & cur_dir[li];
            if (emit_here[li])
            begin
                val = cur_dir[li] ? (PW'(li - 1) - cur_step[li]) : cur_step[li];
            end
        end
        any_emit = |emit_here;
        offset   = PW'($countones(carry_up));

        result.pos  = val + offset;
        result.last = ~any_emit & cur_phase & ~(|carry_up);

        for (int li = LO; li <= HI; li++)
        begin
            step_next[li] = cur_step[li];
            dir_next[li]  = cur_dir[li];
            if (emit_here[li])
            begin
                step_next[li] = cur_step[li] + PW'(1);
            end
            else if (wrap_here[li])
            begin
                step_next[li] = '0;
                dir_next[li]  = ~cur_dir[li];
            end
        end
        phase_next = any_emit ? cur_phase : ~cur_phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            for (int li = LO; li <= HI; li++)
            begin
                step_reg[li] <= '0;
                dir_reg[li]  <= 1'b1;
            end
        end
        else if (clear)
        begin
            phase_reg <= 1'b0;
            for (int li = LO; li <= HI; li++)
            begin
                step_reg[li] <= '0;
                dir_reg[li]  <= 1'b1;
            end
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            for (int li = LO; li <= HI; li++)
            begin
                step_reg[li] <= step_next[li];
                dir_reg[li]  <= dir_next[li];
            end
        end
    end

endmodule

// ===== hw/rtl/adjacent_swap_permutation_sequencer.sv =====
// ----------------------------------------------------------------------------
// adjacent_swap_permutation_sequencer
// Emits the plain-changes adjacent swap positions, one per request.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid, in_stall, restart) yields one
// result on the output channel (out_valid, out_stall, swap_left, cycle_last).
// swap_left is the left index p of the swap of positions p and p+1; applying
// the swaps in order walks all n! permutations. cycle_last marks the swap
// that returns to the identity. restart set in a request starts the sequence
// over before that request's swap is produced.
// The element count is written through cfg_valid/cfg_ready/cfg_data; a write
// also restarts the sequence. Write it only while no result is pending.
// The result of a request appears in the cycle after it is taken, and one
// request is taken per cycle while in_stall is low: the level counters and
// their carry chain are combinational and feed the result register directly.
// Reset sets n to 4 and puts the sequence at its start. While the receiver
// stalls, the result register holds and in_stall is raised once it is full;
// a request is still taken in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module adjacent_swap_permutation_sequencer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sjt_pkg::N_W-1:0]         cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sjt_pkg::POS_W-1:0]       swap_left,
    output logic                            cycle_last
);

    logic [sjt_pkg::N_W-1:0] num_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [sjt_pkg::POS_W-1:0] pos_reg;
    logic                    last_reg;
    logic                    cfg_write;
    logic                    accept_in;
    sjt_pkg::sjt_result_t    result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept_in = in_valid & ~in_stall;

    sjt_levels u_levels
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_write),
        .advance (accept_in),
        .restart (restart),
        .n_eff   (sjt_pkg::eff_n(num_reg)),
        .result  (result)
    );

    always_comb
    begin
        if (accept_in)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg       <= sjt_pkg::N_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                num_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            pos_reg  <= result.pos;
            last_reg <= result.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign swap_left  = pos_reg;
    assign cycle_last = last_reg;

    // A full, stalled result register must hold off new requests.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> in_stall)
        else $error("request taken while result register is full and stalled");

    // Every taken request shows up as a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> out_valid_reg)
        else $error("taken request produced no result");

    // The swap that closes the cycle is always the swap of the first pair.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> pos_reg == '0)
        else $error("cycle end flagged on a swap other than position zero");

endmodule
